### rtl/dtsp_pkg.sv
// Shared types, token codes and helper functions for the device tree structure parser.
package dtsp_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned WordBytes = 4;
    localparam int unsigned WordsLeftW = 31;

    localparam logic [WordW-1:0] TokBeginNode = 32'h0000_0001;
    localparam logic [WordW-1:0] TokEndNode   = 32'h0000_0002;
    localparam logic [WordW-1:0] TokProp      = 32'h0000_0003;
    localparam logic [WordW-1:0] TokNop       = 32'h0000_0004;
    localparam logic [WordW-1:0] TokEnd       = 32'h0000_0009;

    localparam logic [7:0] ByteMask = 8'hFF;

    typedef enum logic [2:0] {
        PH_TOKEN = 3'd0,
        PH_NAME  = 3'd1,
        PH_PLEN  = 3'd2,
        PH_PNAME = 3'd3,
        PH_VALUE = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PROP    = 2'd0,
        KIND_END     = 2'd1,
        KIND_UNKNOWN = 2'd2
    } kind_t;

    typedef enum logic {
        CFG_STRUCT_OFFSET  = 1'b0,
        CFG_STRINGS_OFFSET = 1'b1
    } cfg_index_t;

    typedef struct packed {
        phase_t                phase;
        logic [WordW-1:0]      byte_position;
        logic [WordW-1:0]      node_start;
        logic [WordW-1:0]      prop_length;
        logic [WordsLeftW-1:0] words_left;
        logic                  finished;
    } parse_state_t;

    typedef struct packed {
        logic [WordW-1:0] tag;
        logic [WordW-1:0] value_length;
        logic [WordW-1:0] value_offset;
        logic [WordW-1:0] prop_name_offset;
        logic [WordW-1:0] node_name_offset;
    } event_data_t;

    // Reverse byte order: memory byte 0 becomes the most significant byte.
    function automatic logic [WordW-1:0] swap_word(input logic [WordW-1:0] w);
        swap_word = {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    function automatic logic has_zero_byte(input logic [WordW-1:0] w);
        has_zero_byte = ((w[7:0] & ByteMask) == 8'd0) || ((w[15:8] & ByteMask) == 8'd0) ||
                        ((w[23:16] & ByteMask) == 8'd0) || ((w[31:24] & ByteMask) == 8'd0);
    endfunction

endpackage

### rtl/dtsp_step.sv
// Next-state and event logic for one structure-block word.
module dtsp_step
    import dtsp_pkg::*;
(
    input  parse_state_t      cur,
    input  logic [WordW-1:0]  word,
    input  logic              first,
    input  logic              stop,
    input  logic [WordW-1:0]  struct_offset,
    input  logic [WordW-1:0]  strings_offset,
    output parse_state_t      nxt,
    output logic              ev_valid,
    output kind_t             ev_kind,
    output event_data_t       ev_data
);

    parse_state_t           base;
    logic [WordW-1:0]       v;
    logic [WordW-1:0]       pos;
    logic [WordsLeftW-1:0]  wl;

    always_comb
    begin
        base = cur;
        if (first)
        begin
            base = '0;
            base.phase = PH_TOKEN;
        end

        v   = swap_word(word);
        pos = base.byte_position + WordW'(WordBytes);
        wl  = {1'b0, base.prop_length[WordW-1:2]} + WordsLeftW'(base.prop_length[1:0] != 2'd0);

        nxt      = base;
        ev_valid = 1'b0;
        ev_kind  = KIND_PROP;
        ev_data  = '0;

        if (stop)
        begin
            nxt.finished = 1'b1;
        end
        else if (!base.finished)
        begin
            nxt.byte_position = pos;
            unique case (base.phase)
                PH_TOKEN:
                begin
                    if (v == TokBeginNode)
                    begin
                        nxt.node_start = pos;
                        nxt.phase      = PH_NAME;
                    end
                    else if (v == TokProp)
                    begin
                        nxt.phase = PH_PLEN;
                    end
                    else if (v != TokEndNode && v != TokNop)
                    begin
                        ev_valid    = 1'b1;
                        ev_kind     = (v == TokEnd) ? KIND_END : KIND_UNKNOWN;
                        ev_data.tag = v;
                        if (v == TokEnd)
                            nxt.finished = 1'b1;
                    end
                end
                PH_NAME:
                begin
                    if (has_zero_byte(word))
                        nxt.phase = PH_TOKEN;
                end
                PH_PLEN:
                begin
                    nxt.prop_length = v;
                    nxt.phase       = PH_PNAME;
                end
                PH_PNAME:
                begin
                    ev_valid                 = 1'b1;
                    ev_kind                  = KIND_PROP;
                    ev_data.node_name_offset = struct_offset + base.node_start;
                    ev_data.prop_name_offset = strings_offset + v;
                    ev_data.value_offset     = struct_offset + pos;
                    ev_data.value_length     = base.prop_length;
                    ev_data.tag              = TokProp;
                    nxt.words_left           = wl;
                    nxt.phase                = (wl == '0) ? PH_TOKEN : PH_VALUE;
                end
                default:
                begin
                    if (base.words_left != '0)
                        nxt.words_left = base.words_left - WordsLeftW'(1);
                    if (base.words_left <= WordsLeftW'(1))
                        nxt.phase = PH_TOKEN;
                end
            endcase
        end
    end

endmodule

### rtl/devicetree_struct_parser_unit.sv
// Top level of the flattened device tree structure-block parser.
//
//  channel | direction | tdata                                  | tuser
//  --------+-----------+----------------------------------------+----------------
//  s_*     | in        | word[31:0]                             | first, stop
//  m_*     | out       | node, prop name, value off, len, tag   | kind[1:0]
//  cfg_*   | in        | cfg_data = register value              | cfg_index
//
// Flow: one word per clock while the output is not stalled; a word is held in the input
// register, then the parser logic updates state and loads the result register,
// from which the event is presented on m_*.
// Reset: rst_n clears the parser state, both offset registers and all valid flags.
// Stalls: while the result register holds an untaken event the input register
// holds; s_tready falls only when both stages are full.
module devicetree_struct_parser_unit
    import dtsp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // [31:0] word
    input  logic [1:0]   s_tuser,   // [0] first, [1] stop

    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata,   // [31:0] node_name_offset, [63:32] prop_name_offset,
                                    // [95:64] value_offset, [127:96] value_length,
                                    // [159:128] tag
    output logic [1:0]   m_tuser,   // [1:0] kind

    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data
);

    // Configuration registers.
    logic [WordW-1:0] struct_offset_reg;
    logic [WordW-1:0] strings_offset_reg;

    // Input stage.
    logic             in_valid_reg;
    logic [WordW-1:0] in_word_reg;
    logic             in_first_reg;
    logic             in_stop_reg;

    // Parser state.
    parse_state_t     state_reg;
    parse_state_t     state_next;

    // Result stage.
    logic             out_valid_reg;
    kind_t            out_kind_reg;
    event_data_t      out_data_reg;

    logic             ev_valid;
    kind_t            ev_kind;
    event_data_t      ev_data;
    logic             advance;

    // The work stage moves whenever the result register is empty or being taken.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

    dtsp_step u_step (
        .cur            (state_reg),
        .word           (in_word_reg),
        .first          (in_first_reg),
        .stop           (in_stop_reg),
        .struct_offset  (struct_offset_reg),
        .strings_offset (strings_offset_reg),
        .nxt            (state_next),
        .ev_valid       (ev_valid),
        .ev_kind        (ev_kind),
        .ev_data        (ev_data)
    );

    // Write the offset registers; no read-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            struct_offset_reg  <= '0;
            strings_offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STRUCT_OFFSET:  struct_offset_reg  <= cfg_data;
                CFG_STRINGS_OFFSET: strings_offset_reg <= cfg_data;
                default:            struct_offset_reg  <= struct_offset_reg;
            endcase
        end
    end

    // Input register: load on every transfer, drop the valid flag once consumed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_word_reg  <= s_tdata;
            in_first_reg <= s_tuser[0];
            in_stop_reg  <= s_tuser[1];
        end
    end

    // Advance parser state once per consumed word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // All-zero state: expect token at byte zero.
            state_reg <= '0;
        end
        else if (in_valid_reg && advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register: hold until the downstream transfer completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg && ev_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg && ev_valid)
        begin
            out_kind_reg <= ev_kind;
            out_data_reg <= ev_data;
        end
    end

endmodule

### tb/devicetree_struct_parser_unit_test.sv
// Self-checking testbench for the device tree structure-block parser.
module devicetree_struct_parser_unit_test;
    import dtsp_pkg::*;

    localparam int unsigned CycleLimit = 200000;
    // Two stages between word and event; allow a few more before a register write.
    localparam int unsigned SettleCycles = 6;
    localparam int unsigned HoldOffCycles = 400;

    typedef struct {
        logic [31:0] word;
        logic        first;
        logic        stop;
    } word_item_t;

    typedef struct {
        kind_t       kind;
        logic [31:0] node_off;
        logic [31:0] pname_off;
        logic [31:0] value_off;
        logic [31:0] value_len;
        logic [31:0] tag;
    } dt_event_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;
    logic [1:0]   s_tuser = '0;   // [0] first, [1] stop
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;        // node_name_offset, prop_name_offset, value_offset,
                                  // value_length, tag (32 bits each, low to high)
    logic [1:0]   m_tuser;        // [1:0] kind
    logic         cfg_we = 1'b0;
    logic         cfg_index = 1'b0;
    logic [31:0]  cfg_data = '0;

    devicetree_struct_parser_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Words waiting to be offered, and events the parser still owes us.
    word_item_t  words_pending[$];
    dt_event_t   events_due[$];
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    logic        in_xfer = 1'b0;

    // Traffic shaping: calm and hold_armed are set by the sequencer at a rising edge, read at falling edges.
    logic        calm = 1'b0;
    logic        hold_armed = 1'b0;
    logic        hold_seen = 1'b0;
    int unsigned hold_left = 0;

    // Predictor copy of the registers and parser state.
    logic [31:0] struct_base = '0;
    logic [31:0] strings_base = '0;
    phase_t      pr_phase = PH_TOKEN;
    logic [31:0] pr_pos = '0;
    logic [31:0] pr_node = '0;
    logic [31:0] pr_len = '0;
    logic [30:0] pr_left = '0;
    logic        pr_done = 1'b0;

    initial begin
        forever #4 clk = ~clk;
    end

    // Memory word order to token order and back (the swap is its own inverse).
    function automatic logic [31:0] byte_reverse(input logic [31:0] w);
        byte_reverse = {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    function automatic logic any_zero_byte(input logic [31:0] w);
        any_zero_byte = 1'b0;
        for (int b = 0; b < 4; b++)
            if (w[8*b +: 8] == 8'h00)
                any_zero_byte = 1'b1;
    endfunction

    task automatic clear_parse_state();
        pr_phase = PH_TOKEN;
        pr_pos   = '0;
        pr_node  = '0;
        pr_len   = '0;
        pr_left  = '0;
        pr_done  = 1'b0;
    endtask

    // Advance the parser by one word; hit marks that an event is owed.
    task automatic parse_word(input logic [31:0] w, input logic first, input logic stop,
                              output logic hit, output dt_event_t ev);
        logic [31:0] v;
        hit = 1'b0;
        ev  = '{KIND_PROP, '0, '0, '0, '0, '0};
        if (first)
            clear_parse_state();
        if (stop) begin
            pr_done = 1'b1;
            return;
        end
        if (pr_done)
            return;
        v = byte_reverse(w);
        pr_pos = pr_pos + WordBytes;
        case (pr_phase)
            PH_TOKEN: begin
                if (v == TokBeginNode) begin
                    pr_node  = pr_pos;
                    pr_phase = PH_NAME;
                end else if (v == TokProp) begin
                    pr_phase = PH_PLEN;
                end else if (v != TokEndNode && v != TokNop) begin
                    ev.kind = (v == TokEnd) ? KIND_END : KIND_UNKNOWN;
                    ev.tag  = v;
                    hit     = 1'b1;
                    if (v == TokEnd)
                        pr_done = 1'b1;
                end
            end
            PH_NAME: begin
                if (any_zero_byte(w))
                    pr_phase = PH_TOKEN;
            end
            PH_PLEN: begin
                pr_len   = v;
                pr_phase = PH_PNAME;
            end
            PH_PNAME: begin
                ev.kind      = KIND_PROP;
                ev.node_off  = struct_base + pr_node;
                ev.pname_off = strings_base + v;
                ev.value_off = struct_base + pr_pos;
                ev.value_len = pr_len;
                ev.tag       = TokProp;
                hit          = 1'b1;
                // Round up to whole words; 31 bits hold the count without overflow.
                pr_left  = {1'b0, pr_len[31:2]} + {30'd0, |pr_len[1:0]};
                pr_phase = (pr_left == '0) ? PH_TOKEN : PH_VALUE;
            end
            default: begin
                if (pr_left != '0)
                    pr_left = pr_left - 1'b1;
                if (pr_left == '0)
                    pr_phase = PH_TOKEN;
            end
        endcase
    endtask

    // Track transfers on both sides: predict on input, check on output.
    always @(posedge clk) begin : track
        dt_event_t   ev;
        dt_event_t   want;
        logic        hit;
        logic [31:0] got_node;
        logic [31:0] got_pname;
        logic [31:0] got_voff;
        logic [31:0] got_vlen;
        logic [31:0] got_tag;
        in_xfer <= rst_n && s_tvalid && s_tready;
        if (rst_n) begin
            if (cfg_we) begin
                if (cfg_index == CFG_STRUCT_OFFSET)
                    struct_base = cfg_data;
                else
                    strings_base = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                parse_word(s_tdata, s_tuser[0], s_tuser[1], hit, ev);
                if (hit)
                    events_due.push_back(ev);
            end
            if (m_tvalid && m_tready) begin
                if (events_due.size() == 0) begin
                    $error("unexpected event: kind %0d tag %h", m_tuser, m_tdata[159:128]);
                    fail_count++;
                end else begin
                    want      = events_due.pop_front();
                    got_node  = m_tdata[31:0];
                    got_pname = m_tdata[63:32];
                    got_voff  = m_tdata[95:64];
                    got_vlen  = m_tdata[127:96];
                    got_tag   = m_tdata[159:128];
                    if (m_tuser != want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, m_tuser);
                        fail_count++;
                    end
                    if (got_node != want.node_off) begin
                        $error("node_name_offset: expected %h, got %h", want.node_off, got_node);
                        fail_count++;
                    end
                    if (got_pname != want.pname_off) begin
                        $error("prop_name_offset: expected %h, got %h",
                               want.pname_off, got_pname);
                        fail_count++;
                    end
                    if (got_voff != want.value_off) begin
                        $error("value_offset: expected %h, got %h", want.value_off, got_voff);
                        fail_count++;
                    end
                    if (got_vlen != want.value_len) begin
                        $error("value_length: expected %h, got %h", want.value_len, got_vlen);
                        fail_count++;
                    end
                    if (got_tag != want.tag) begin
                        $error("tag: expected %h, got %h", want.tag, got_tag);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Sender: offer the next word once the current one has transferred.
    always @(negedge clk) begin : drive_words
        word_item_t it;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_xfer) begin
            if (words_pending.size() != 0 && (calm || $urandom_range(99) >= 7)) begin
                it = words_pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= it.word;
                s_tuser  <= {it.stop, it.first};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off to back the block up.
    always @(negedge clk) begin : drive_ready
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_armed && !hold_seen) begin
            hold_seen <= 1'b1;
            hold_left <= HoldOffCycles;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 7);
        end
    end

    always @(posedge clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic put(input logic [31:0] w, input logic first, input logic stop);
        word_item_t it;
        it.word  = w;
        it.first = first;
        it.stop  = stop;
        words_pending.push_back(it);
    endtask

    task automatic put_tok(input logic [31:0] tok);
        put(byte_reverse(tok), 1'b0, 1'b0);
    endtask

    function automatic logic [31:0] name_chars();
        name_chars = {8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                      8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))};
    endfunction

    // Name of zero to two full words, then a word holding the terminator.
    task automatic add_name();
        logic [31:0] w;
        int          n;
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++)
            put(name_chars(), 1'b0, 1'b0);
        w = ($urandom_range(3) == 0) ? $urandom : name_chars();
        w[8*$urandom_range(0, 3) +: 8] = 8'h00;
        put(w, 1'b0, 1'b0);
    endtask

    task automatic add_prop(input logic [31:0] len);
        put_tok(TokProp);
        put(byte_reverse(len), 1'b0, 1'b0);
        put($urandom, 1'b0, 1'b0);
        for (int unsigned i = 0; i < (len + 3) / 4; i++)
            put($urandom, 1'b0, 1'b0);
    endtask

    task automatic restart_block();
        put(byte_reverse(TokBeginNode), 1'b1, 1'b0);
        add_name();
    endtask

    // Mostly well-formed blocks with random content, some noise and broken runs.
    task automatic add_random_blocks(input int unsigned n);
        int unsigned goal;
        int unsigned r;
        logic [31:0] len;
        goal = words_pending.size() + n;
        restart_block();
        while (words_pending.size() < goal) begin
            r = $urandom_range(99);
            if (r < 20) begin
                put_tok(TokBeginNode);
                add_name();
            end else if (r < 55) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16);
                add_prop(len);
            end else if (r < 63) begin
                put_tok(TokEndNode);
            end else if (r < 70) begin
                put_tok(TokNop);
            end else if (r < 78) begin
                put($urandom, 1'b0, 1'b0);
            end else if (r < 81) begin
                put_tok(TokEnd);
                repeat ($urandom_range(0, 2))
                    put($urandom, 1'b0, 1'b0);
                restart_block();
            end else if (r < 84) begin
                put($urandom, 1'($urandom_range(1)), 1'b1);
                restart_block();
            end else if (r < 88) begin
                restart_block();
            end else if (r < 92) begin
                // Huge length: skip a few value words, then abandon the block.
                len = $urandom | 32'h8000_0000;
                add_prop(0);
                void'(words_pending.pop_back());
                void'(words_pending.pop_back());
                put(byte_reverse(len), 1'b0, 1'b0);
                put($urandom, 1'b0, 1'b0);
                repeat ($urandom_range(1, 4))
                    put($urandom, 1'b0, 1'b0);
                restart_block();
            end else if (r < 96) begin
                // Node name cut short by a stop request.
                put_tok(TokBeginNode);
                put(name_chars(), 1'b0, 1'b0);
                put($urandom, 1'b0, 1'b1);
                restart_block();
            end else begin
                // Property cut off mid-value by a new block.
                put_tok(TokProp);
                put(byte_reverse(32'd40), 1'b0, 1'b0);
                put($urandom, 1'b0, 1'b0);
                put($urandom, 1'b0, 1'b0);
                restart_block();
            end
        end
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait for every word to transfer and every event to arrive, then settle.
    task automatic drain();
        while (words_pending.size() != 0 || s_tvalid)
            @(posedge clk);
        while (events_due.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    initial begin : sequencer
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Directed words with the registers at their reset values.
        put(byte_reverse(TokProp), 1'b1, 1'b0);    // property before any node
        put(byte_reverse(32'd0), 1'b0, 1'b0);
        put(32'hFFFF_FFFF, 1'b0, 1'b0);
        put_tok(TokBeginNode);
        put(32'h0000_0000, 1'b0, 1'b0);            // name ends at once
        put_tok(TokNop);
        put_tok(TokEndNode);
        put(32'h0000_0000, 1'b0, 1'b0);            // unknown tag zero
        put(32'hFFFF_FFFF, 1'b0, 1'b0);            // unknown tag all ones
        put_tok(TokBeginNode);
        put(32'h0101_0101, 1'b0, 1'b0);
        put(32'h0043_4241, 1'b0, 1'b0);            // terminator in the top byte
        put_tok(TokProp);
        put(byte_reverse(32'd5), 1'b0, 1'b0);
        put(32'h0000_0000, 1'b0, 1'b0);
        put(32'hFFFF_FFFF, 1'b0, 1'b0);
        put(32'h0000_0000, 1'b0, 1'b0);
        put_tok(TokProp);                          // huge length, then stop mid-value
        put(32'hFFFF_FFFF, 1'b0, 1'b0);
        put(32'h1234_5678, 1'b0, 1'b0);
        put(32'hDEAD_BEEF, 1'b0, 1'b0);
        put(32'hA5A5_A5A5, 1'b0, 1'b1);
        put(byte_reverse(TokProp), 1'b0, 1'b0);    // ignored once finished
        put(byte_reverse(TokEnd), 1'b1, 1'b1);     // restart and stop together
        put(byte_reverse(TokEnd), 1'b1, 1'b0);
        put(byte_reverse(TokProp), 1'b0, 1'b0);    // ignored after end
        drain();

        // Extremes of both offsets, no idling on either side.
        write_reg(CFG_STRUCT_OFFSET, 32'hFFFF_FFFF);
        write_reg(CFG_STRINGS_OFFSET, 32'hFFFF_FFFF);
        @(posedge clk);
        calm = 1'b1;
        add_random_blocks(300);
        drain();
        calm = 1'b0;

        write_reg(CFG_STRUCT_OFFSET, 32'h0000_0000);
        write_reg(CFG_STRINGS_OFFSET, 32'h0000_0000);
        @(posedge clk);
        add_random_blocks(300);
        drain();

        // Back-pressure: a burst of error events while the receiver holds off.
        write_reg(CFG_STRUCT_OFFSET, $urandom);
        write_reg(CFG_STRINGS_OFFSET, $urandom);
        @(posedge clk);
        put(byte_reverse(TokBeginNode), 1'b1, 1'b0);
        put(32'h0000_0000, 1'b0, 1'b0);
        repeat (30)
            put(byte_reverse($urandom | 32'h8000_0000), 1'b0, 1'b0);
        hold_armed = 1'b1;
        add_random_blocks(300);
        drain();

        write_reg(CFG_STRUCT_OFFSET, $urandom | 32'hF000_0000);
        write_reg(CFG_STRINGS_OFFSET, $urandom);
        @(posedge clk);
        add_random_blocks(400);
        drain();

        if (events_due.size() != 0) begin
            $error("events never delivered: %0d", events_due.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/dtsp_pkg.sv
rtl/dtsp_step.sv
rtl/devicetree_struct_parser_unit.sv
tb/devicetree_struct_parser_unit_test.sv
